// File: sv/bure_pkg.sv
package bure_pkg;

    // Commands carried in the input item's tuser.
    typedef enum logic [2:0] {
        CMD_PUT       = 3'd0,
        CMD_GET       = 3'd1,
        CMD_AVAILABLE = 3'd2,
        CMD_RX_BYTE   = 3'd3,
        CMD_TX_READY  = 3'd4,
        CMD_TX_DONE   = 3'd5
    } cmd_t;

    // Status codes of a result item.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TX_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RX_EMPTY = 2'd2;

    localparam int unsigned BYTE_W = 8;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // Result item; the last member lands in the lowest bits of tdata.
    typedef struct packed {
        logic              rx_overflow_flag;
        logic              drain_on;
        logic              receiver_on;
        logic              tx_byte_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              rx_not_empty;
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
        logic [1:0]        status;
    } result_t;

endpackage

// File: sv/bure_ram.sv
module bure_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/buffered_uart_ring_engine.sv
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  tuser[2:0] command, tdata[7:0] data
// m_axis    out        m_tvalid/m_tready  tdata[23:0] result fields, status lowest
// cfg       in         cfg_we             cfg_wdata duplex mode
//
// A put, an available, a received byte, a transmit complete or a command that
// finds nothing to read goes straight to a result; a get or a transmitter
// ready that takes a byte waits in ST_READ on the ring memory's read port.
// Reset leaves both rings empty, the receiver on and draining off; no
// clearing pass is needed. A stalled result sits in the output register and
// the next item is taken in the same cycle that register is emptied.
module buffered_uart_ring_engine #(
    parameter int RING_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [2:0]  s_tuser,   // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] status, [9:2] read_data, [10] read_valid,
                                   // [11] rx_not_empty, [19:12] tx_byte,
                                   // [20] tx_byte_valid, [21] receiver_on,
                                   // [22] drain_on, [23] rx_overflow_flag
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    localparam int AW = $clog2(RING_DEPTH);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        ring_next = (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    bure_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [AW-1:0]     tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic              rx_en_reg, rx_en_next;
    logic              drain_reg, drain_next;
    logic              ovf_reg, ovf_next;
    logic              duplex_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    bure_pkg::result_t out_reg, out_next;
    logic              fill_rx_reg, fill_rx_next;

    logic              accept;
    bure_pkg::cmd_t    cmd;
    logic [AW-1:0]     tx_tail_inc, rx_tail_inc;
    logic              rx_wr_en, tx_wr_en;
    logic [AW-1:0]     rx_rd_addr, tx_rd_addr;
    logic [7:0]        rx_rd_data, tx_rd_data;
    logic              need_read;
    logic [1:0]        status;
    logic              rd_valid, txb_valid;

    assign s_tready = (state_reg == bure_pkg::ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = bure_pkg::cmd_t'(s_tuser);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    assign tx_tail_inc = ring_next(tx_tail_reg);
    assign rx_tail_inc = ring_next(rx_tail_reg);
    assign rx_rd_addr  = rx_head_reg;
    assign tx_rd_addr  = tx_head_reg;

    // Ring memories; a write and a read never fall in the same item, so the
    // write lands before any later read of that entry.
    bure_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_tail_reg),
        .wr_data (s_tdata),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    bure_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_tail_reg),
        .wr_data (s_tdata),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    // Command decode, pointer update and result assembly.
    always_comb
    begin
        state_next    = state_reg;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        rx_en_next    = rx_en_reg;
        drain_next    = drain_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        fill_rx_next  = fill_rx_reg;
        rx_wr_en      = 1'b0;
        tx_wr_en      = 1'b0;
        need_read     = 1'b0;
        status        = bure_pkg::STATUS_OK;
        rd_valid      = 1'b0;
        txb_valid     = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            bure_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        bure_pkg::CMD_PUT:
                        begin
                            drain_next = 1'b0;
                            if (tx_tail_inc == tx_head_reg)
                            begin
                                status = bure_pkg::STATUS_TX_FULL;
                            end
                            else
                            begin
                                tx_wr_en     = 1'b1;
                                tx_tail_next = tx_tail_inc;
                            end
                            if (tx_tail_next != tx_head_reg)
                            begin
                                if (!duplex_reg)
                                begin
                                    rx_en_next = 1'b0;
                                end
                                drain_next = 1'b1;
                            end
                        end
                        bure_pkg::CMD_GET:
                        begin
                            if (rx_head_reg == rx_tail_reg)
                            begin
                                status = bure_pkg::STATUS_RX_EMPTY;
                            end
                            else
                            begin
                                rd_valid     = 1'b1;
                                need_read    = 1'b1;
                                rx_head_next = ring_next(rx_head_reg);
                            end
                        end
                        bure_pkg::CMD_RX_BYTE:
                        begin
                            if (rx_en_reg)
                            begin
                                if (rx_tail_inc != rx_head_reg)
                                begin
                                    rx_wr_en     = 1'b1;
                                    rx_tail_next = rx_tail_inc;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        bure_pkg::CMD_TX_READY:
                        begin
                            if (drain_reg)
                            begin
                                if (tx_tail_reg != tx_head_reg)
                                begin
                                    txb_valid    = 1'b1;
                                    need_read    = 1'b1;
                                    tx_head_next = ring_next(tx_head_reg);
                                end
                                if (tx_tail_reg == tx_head_next)
                                begin
                                    drain_next = 1'b0;
                                end
                            end
                        end
                        bure_pkg::CMD_TX_DONE:
                        begin
                            if ((tx_tail_reg == tx_head_reg) && !duplex_reg)
                            begin
                                rx_en_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    out_next.status           = status;
                    out_next.read_data        = '0;
                    out_next.read_valid       = rd_valid;
                    out_next.rx_not_empty     = (rx_head_next != rx_tail_next);
                    out_next.tx_byte          = '0;
                    out_next.tx_byte_valid    = txb_valid;
                    out_next.receiver_on      = rx_en_next;
                    out_next.drain_on         = drain_next;
                    out_next.rx_overflow_flag = ovf_next;
                    fill_rx_next              = rd_valid;

                    // A byte from a ring comes through the memory's registered read port, so the item waits in ST_READ.
                    if (need_read)
                    begin
                        m_tvalid_next = 1'b0;
                        state_next    = bure_pkg::ST_READ;
                    end
                    else
                    begin
                        m_tvalid_next = 1'b1;
                    end
                end
            end
            bure_pkg::ST_READ:
            begin
                if (fill_rx_reg)
                begin
                    out_next.read_data = rx_rd_data;
                end
                else
                begin
                    out_next.tx_byte = tx_rd_data;
                end
                m_tvalid_next = 1'b1;
                state_next    = bure_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bure_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bure_pkg::ST_IDLE;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            rx_en_reg    <= 1'b1;
            drain_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            duplex_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            rx_en_reg    <= rx_en_next;
            drain_reg    <= drain_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                duplex_reg <= cfg_wdata;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        fill_rx_reg <= fill_rx_next;
    end

    // A queued transmit byte always means draining is on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_head_reg != tx_tail_reg) |-> drain_reg)
        else $error("transmit ring holds data with draining off");

    // No result is shown while a ring read is outstanding.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bure_pkg::ST_READ) |-> !m_tvalid_reg)
        else $error("result shown during ring read");

    // A ring read ends with ST_READ followed directly by ST_IDLE and the result shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bure_pkg::ST_READ) |=> (state_reg == bure_pkg::ST_IDLE) && m_tvalid_reg)
        else $error("ring read did not complete");

    // Pointers stay inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(rx_tail_reg) < RING_DEPTH) && (32'(tx_tail_reg) < RING_DEPTH)
        && (32'(rx_head_reg) < RING_DEPTH) && (32'(tx_head_reg) < RING_DEPTH))
        else $error("ring pointer out of range");

    // The overflow flag never clears once set.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

endmodule
